@@ rtl/bdeq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the bounded double-ended queue.
// No dependencies.
package bdeq_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int DATA_W       = 32;
    localparam int CMD_W        = 3;
    localparam int STATUS_W     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_LIST       = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RESP,
        S_LIST_RD,
        S_LIST_SEND
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic exec;
        logic rd_en;
        logic idx_next;
        logic show_entry;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic list_last;
    } sts_t;

endpackage

@@ rtl/bdeq_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine for the double-ended queue.
// Depends on bdeq_pkg.
module bdeq_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bdeq_pkg::CMD_W-1:0]    s_cmd,
    output logic                          m_valid,
    input  logic                          m_ready,
    input  bdeq_pkg::sts_t                sts,
    output bdeq_pkg::ctl_t                ctl
);

    bdeq_pkg::state_t state_reg;
    bdeq_pkg::state_t state_next;
    logic             code_ok;
    logic             is_list;

    always_comb begin
        code_ok = 1'b0;
        is_list = 1'b0;
        unique case (s_cmd)
            bdeq_pkg::CMD_PUSH_FRONT,
            bdeq_pkg::CMD_PUSH_BACK,
            bdeq_pkg::CMD_POP_FRONT,
            bdeq_pkg::CMD_POP_BACK: code_ok = 1'b1;
            bdeq_pkg::CMD_LIST: begin
                code_ok = 1'b1;
                is_list = 1'b1;
            end
            default: code_ok = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bdeq_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bdeq_pkg::S_IDLE: begin
                if (s_valid && code_ok) begin
                    if (is_list && !sts.empty) begin
                        state_next = bdeq_pkg::S_LIST_RD;
                    end else begin
                        state_next = bdeq_pkg::S_RESP;
                    end
                end
            end
            bdeq_pkg::S_RESP: begin
                if (m_ready) begin
                    state_next = bdeq_pkg::S_IDLE;
                end
            end
            bdeq_pkg::S_LIST_RD: begin
                state_next = bdeq_pkg::S_LIST_SEND;
            end
            bdeq_pkg::S_LIST_SEND: begin
                if (m_ready) begin
                    state_next = sts.list_last ? bdeq_pkg::S_IDLE : bdeq_pkg::S_LIST_RD;
                end
            end
            default: state_next = bdeq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        m_valid        = 1'b0;
        ctl.exec       = 1'b0;
        ctl.rd_en      = 1'b0;
        ctl.idx_next   = 1'b0;
        ctl.show_entry = 1'b0;
        unique case (state_reg)
            bdeq_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                ctl.exec = s_valid && code_ok;
            end
            bdeq_pkg::S_RESP: begin
                m_valid = 1'b1;
            end
            bdeq_pkg::S_LIST_RD: begin
                ctl.rd_en = 1'b1;
            end
            bdeq_pkg::S_LIST_SEND: begin
                m_valid        = 1'b1;
                ctl.show_entry = 1'b1;
                ctl.idx_next   = m_ready && !sts.list_last;
            end
            default: s_ready = 1'b0;
        endcase
    end

endmodule

@@ rtl/bdeq_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the double-ended queue: ring store, front and count registers,
// list cursor and result payload. Depends on bdeq_pkg.
module bdeq_datapath #(
    parameter int CAPACITY = bdeq_pkg::CAPACITY_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [bdeq_pkg::CMD_W-1:0]        s_cmd,
    input  logic signed [bdeq_pkg::DATA_W-1:0] s_value,
    output logic signed [bdeq_pkg::DATA_W-1:0] m_entry_value,
    output logic [bdeq_pkg::STATUS_W-1:0]     m_status,
    output logic                              m_last,
    input  bdeq_pkg::ctl_t                    ctl,
    output bdeq_pkg::sts_t                    sts
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW:0]   CAP_W   = (AW+1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
    localparam logic [AW-1:0] LAST_POS = AW'(CAPACITY - 1);

    logic [bdeq_pkg::DATA_W-1:0] mem [CAPACITY];

    logic [AW-1:0]               front_reg, front_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [AW-1:0]               idx_reg;
    logic [bdeq_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [bdeq_pkg::DATA_W-1:0] rdata_reg;

    logic          full;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] back_addr;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] front_dec;
    logic [AW-1:0] front_inc;
    logic [AW:0]   back_sum;
    logic [AW:0]   rd_sum;

    assign full      = (count_reg == CAP_CNT);
    assign sts.empty = (count_reg == '0);
    assign sts.list_last = (({1'b0, idx_reg} + (AW+1)'(1)) == (AW+1)'(count_reg));

    assign front_dec = (front_reg == '0) ? LAST_POS : front_reg - AW'(1);
    assign front_inc = (front_reg == LAST_POS) ? '0 : front_reg + AW'(1);

    assign back_sum  = {1'b0, front_reg} + {1'b0, count_reg[AW-1:0]};
    assign back_addr = (back_sum >= CAP_W) ? AW'(back_sum - CAP_W) : back_sum[AW-1:0];

    assign rd_sum  = {1'b0, front_reg} + {1'b0, idx_reg};
    assign rd_addr = (rd_sum >= CAP_W) ? AW'(rd_sum - CAP_W) : rd_sum[AW-1:0];

    always_comb begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = back_addr;
        if (ctl.exec) begin
            status_next = bdeq_pkg::ST_OK;
            unique case (s_cmd)
                bdeq_pkg::CMD_PUSH_FRONT: begin
                    if (full) begin
                        status_next = bdeq_pkg::ST_FULL;
                    end else begin
                        front_next = front_dec;
                        wr_addr    = front_dec;
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                bdeq_pkg::CMD_PUSH_BACK: begin
                    if (full) begin
                        status_next = bdeq_pkg::ST_FULL;
                    end else begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                bdeq_pkg::CMD_POP_FRONT: begin
                    if (sts.empty) begin
                        status_next = bdeq_pkg::ST_EMPTY;
                    end else begin
                        front_next = front_inc;
                        count_next = count_reg - CW'(1);
                    end
                end
                bdeq_pkg::CMD_POP_BACK: begin
                    if (sts.empty) begin
                        status_next = bdeq_pkg::ST_EMPTY;
                    end else begin
                        count_next = count_reg - CW'(1);
                    end
                end
                bdeq_pkg::CMD_LIST: begin
                    if (sts.empty) begin
                        status_next = bdeq_pkg::ST_EMPTY;
                    end
                end
                default: status_next = status_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
        end else begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        if (ctl.exec) begin
            idx_reg <= '0;
        end else if (ctl.idx_next) begin
            idx_reg <= idx_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= s_value;
        end
        if (ctl.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign m_entry_value = ctl.show_entry ? rdata_reg : '0;
    assign m_status      = ctl.show_entry ? bdeq_pkg::ST_OK : status_reg;
    assign m_last        = ctl.show_entry ? sts.list_last : 1'b1;

endmodule

@@ rtl/bounded_double_ended_queue.sv @@
`timescale 1ns / 1ps
// Top level of the bounded double-ended queue: controller plus datapath.
// Depends on bdeq_pkg, bdeq_ctrl and bdeq_datapath.
//
//  channel | ports                                  | moves
//  s_      | s_valid s_ready s_cmd s_value          | one command item
//  m_      | m_valid m_ready m_entry_value m_status | one result item
//          | m_last                                 |
//
// Push, pop and an empty list: accepted in IDLE, result shown the next cycle
// (RESP); another command is taken only once the result has gone.
// List of N entries: after the accept, each entry has a store read (LIST_RD),
// then its result (LIST_SEND), until the last entry has gone.
// Reset clears front position and count; the store needs no clearing.
// A stalled result holds, and no item is taken until it has gone.
module bounded_double_ended_queue #(
    parameter int CAPACITY = bdeq_pkg::CAPACITY_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [bdeq_pkg::CMD_W-1:0]         s_cmd,
    input  logic signed [bdeq_pkg::DATA_W-1:0] s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [bdeq_pkg::DATA_W-1:0] m_entry_value,
    output logic [bdeq_pkg::STATUS_W-1:0]      m_status,
    output logic                               m_last
);

    bdeq_pkg::ctl_t ctl;
    bdeq_pkg::sts_t sts;

    bdeq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    bdeq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_cmd         (s_cmd),
        .s_value       (s_value),
        .m_entry_value (m_entry_value),
        .m_status      (m_status),
        .m_last        (m_last),
        .ctl           (ctl),
        .sts           (sts)
    );

endmodule
